### src/alf_pkg.sv
// Shared constants, character codes and controller/datapath interface types.
package alf_pkg;

	localparam int LEAD_DEPTH = 32;
	localparam int LEAD_CW    = $clog2(LEAD_DEPTH + 1);
	localparam int LEAD_IW    = (LEAD_DEPTH > 1) ? $clog2(LEAD_DEPTH) : 1;

	localparam int COL_W      = 8;
	localparam int TAB_WIDTH  = 8;

	localparam logic [COL_W-1:0] TAB_MASK    = 8'hF8;
	localparam logic [COL_W-1:0] TAB_SAT     = COL_W'(256 - TAB_WIDTH);
	localparam logic [COL_W-1:0] COL_MAX     = 8'hFF;
	localparam logic [COL_W-1:0] COMMENT_COL = 8'd32;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h27;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	// status: datapath to controller
	typedef struct packed {
		logic       is_end;
		logic       semi;
		logic [1:0] ntabs;
		logic       pad;
		logic       replay;
		logic       emit;
		logic       pad_needed;
		logic       replay_done;
		logic       out_free;
	} alf_status_t;

	// commands: controller to datapath
	typedef struct packed {
		logic accept;
		logic ld_tab;
		logic ld_char;
		logic ld_blank;
		logic ld_semi;
		logic ld_nl;
	} alf_cmd_t;

endpackage

### src/alf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module alf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

### src/alf_ctrl.sv
// Sequencer: turns one decoded item into a series of output loads.
module alf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  alf_pkg::alf_status_t sts,
	output alf_pkg::alf_cmd_t    cmd
);
	import alf_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TABS,
		S_PAD,
		S_REPLAY,
		S_CHAR,
		S_SEMI,
		S_NL
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] tab_cnt_q, tab_cnt_d;
	logic       pad_q, pad_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		tab_cnt_d = tab_cnt_q;
		pad_d     = pad_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					tab_cnt_d  = sts.ntabs;
					pad_d      = sts.pad;
					if (sts.is_end) begin
						state_d = sts.semi ? S_SEMI : S_NL;
					end else if (sts.ntabs != 2'd0) begin
						state_d = S_TABS;
					end else if (sts.pad) begin
						state_d = S_PAD;
					end else if (sts.replay) begin
						state_d = S_REPLAY;
					end else if (sts.emit) begin
						state_d = S_CHAR;
					end
				end
			end
			S_TABS: begin
				if (sts.out_free) begin
					cmd.ld_tab = 1'b1;
					tab_cnt_d  = tab_cnt_q - 2'd1;
					if (tab_cnt_q == 2'd1) begin
						state_d = pad_q ? S_PAD : S_CHAR;
					end
				end
			end
			S_PAD: begin
				if (sts.out_free) begin
					if (sts.pad_needed) begin
						cmd.ld_tab = 1'b1;
					end else begin
						cmd.ld_char = 1'b1;
						state_d     = S_IDLE;
					end
				end
			end
			S_REPLAY: begin
				if (sts.out_free) begin
					if (sts.replay_done) begin
						cmd.ld_char = 1'b1;
						state_d     = S_IDLE;
					end else begin
						cmd.ld_blank = 1'b1;
					end
				end
			end
			S_CHAR: begin
				if (sts.out_free) begin
					cmd.ld_char = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_SEMI: begin
				if (sts.out_free) begin
					cmd.ld_semi = 1'b1;
					state_d     = S_NL;
				end
			end
			S_NL: begin
				if (sts.out_free) begin
					cmd.ld_nl = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			tab_cnt_q <= 2'd0;
			pad_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			tab_cnt_q <= tab_cnt_d;
			pad_q     <= pad_d;
		end
	end

endmodule

### src/alf_dp.sv
// Datapath: field decode, column tracking, leading-blank store, output register.
module alf_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           in_char,
	input  logic                 line_end,
	input  alf_pkg::alf_cmd_t    cmd,
	output alf_pkg::alf_status_t sts,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_char,
	output logic                 line_done,
	output logic                 bad_line,
	output logic                 overflow
);
	import alf_pkg::*;

	typedef enum logic [3:0] {
		M_LEAD      = 4'd0,
		M_LABEL     = 4'd1,
		M_AFT_LABEL = 4'd2,
		M_OPCODE    = 4'd3,
		M_AFT_OPC   = 4'd4,
		M_OPERAND   = 4'd5,
		M_QUOTE     = 4'd6,
		M_AFT_OPND  = 4'd7,
		M_COMMENT   = 4'd8,
		M_DROP      = 4'd9,
		M_RAW       = 4'd10
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [COL_W-1:0]   column_q, column_d;
	logic [LEAD_CW-1:0] lead_count_q, lead_count_d;
	logic [LEAD_CW-1:0] idx_q, idx_d;
	logic               saw_bad_q, saw_bad_d;
	logic               saw_ovf_q, saw_ovf_d;
	logic [7:0]         char_q;
	logic               out_valid_q;
	logic [7:0]         out_char_q;
	logic               line_done_q, bad_line_q, overflow_q;

	// decode results
	mode_t              dec_mode;
	logic               dec_lead_wr, dec_lead_ovf, dec_bad;
	logic               is_blank;
	logic               lead_rd;
	logic               load;
	logic [7:0]         load_char;

	assign is_blank = (in_char == CH_SP) || (in_char == CH_TAB);

	// Decode one item against the current field.
	always_comb begin
		dec_mode     = mode_q;
		dec_lead_wr  = 1'b0;
		dec_lead_ovf = 1'b0;
		dec_bad      = 1'b0;
		sts          = '0;
		if (line_end) begin
			sts.is_end = 1'b1;
			sts.semi   = (mode_q == M_LEAD);
		end else if (in_char != CH_NUL) begin
			case (mode_q)
				M_LEAD: begin
					if (is_blank) begin
						if (lead_count_q < LEAD_CW'(LEAD_DEPTH)) begin
							dec_lead_wr = 1'b1;
						end else begin
							dec_lead_ovf = 1'b1;
						end
					end else if (in_char == CH_SEMI) begin
						dec_mode   = M_RAW;
						sts.replay = 1'b1;
						sts.emit   = 1'b1;
					end else if (lead_count_q != '0) begin
						sts.ntabs = 2'd1;
						sts.emit  = 1'b1;
						dec_mode  = M_OPCODE;
					end else if (in_char == CH_COLON) begin
						dec_mode = M_AFT_LABEL;
					end else begin
						sts.emit = 1'b1;
						dec_mode = M_LABEL;
					end
				end
				M_LABEL: begin
					if (is_blank || in_char == CH_COLON) begin
						dec_mode = M_AFT_LABEL;
					end else if (in_char == CH_SEMI) begin
						sts.ntabs = 2'd2;
						sts.pad   = 1'b1;
						sts.emit  = 1'b1;
						dec_mode  = M_COMMENT;
					end else begin
						sts.emit = 1'b1;
					end
				end
				M_AFT_LABEL: begin
					if (in_char == CH_SEMI) begin
						sts.ntabs = 2'd2;
						sts.pad   = 1'b1;
						sts.emit  = 1'b1;
						dec_mode  = M_COMMENT;
					end else if (!is_blank) begin
						sts.ntabs = 2'd1;
						sts.emit  = 1'b1;
						dec_mode  = M_OPCODE;
					end
				end
				M_OPCODE: begin
					if (is_blank) begin
						dec_mode = M_AFT_OPC;
					end else if (in_char == CH_SEMI) begin
						sts.ntabs = 2'd1;
						sts.pad   = 1'b1;
						sts.emit  = 1'b1;
						dec_mode  = M_COMMENT;
					end else begin
						sts.emit = 1'b1;
					end
				end
				M_AFT_OPC: begin
					if (in_char == CH_SEMI) begin
						sts.ntabs = 2'd1;
						sts.pad   = 1'b1;
						sts.emit  = 1'b1;
						dec_mode  = M_COMMENT;
					end else if (!is_blank) begin
						sts.ntabs = 2'd1;
						sts.emit  = 1'b1;
						dec_mode  = (in_char == CH_QUOTE) ? M_QUOTE : M_OPERAND;
					end
				end
				M_OPERAND: begin
					if (is_blank) begin
						dec_mode = M_AFT_OPND;
					end else if (in_char == CH_SEMI) begin
						sts.pad  = 1'b1;
						sts.emit = 1'b1;
						dec_mode = M_COMMENT;
					end else begin
						sts.emit = 1'b1;
						dec_mode = (in_char == CH_QUOTE) ? M_QUOTE : M_OPERAND;
					end
				end
				M_QUOTE: begin
					sts.emit = 1'b1;
					if (in_char == CH_QUOTE) begin
						dec_mode = M_OPERAND;
					end
				end
				M_AFT_OPND: begin
					if (in_char == CH_SEMI) begin
						sts.pad  = 1'b1;
						sts.emit = 1'b1;
						dec_mode = M_COMMENT;
					end else if (!is_blank) begin
						dec_bad  = 1'b1;
						dec_mode = M_DROP;
					end
				end
				M_COMMENT, M_RAW: begin
					sts.emit = 1'b1;
				end
				default: begin
				end
			endcase
		end
		sts.pad_needed  = (column_q < COMMENT_COL);
		sts.replay_done = (idx_q == lead_count_q);
		sts.out_free    = !out_valid_q || !out_stall;
	end

	// Leading-blank store: 1 marks a tab, 0 a space.
	alf_ram #(
		.WIDTH(1),
		.DEPTH(LEAD_DEPTH)
	) u_lead_ram (
		.clk     (clk),
		.wr_en   (cmd.accept && dec_lead_wr),
		.wr_addr (lead_count_q[LEAD_IW-1:0]),
		.wr_data (in_char == CH_TAB),
		.rd_addr (idx_d[LEAD_IW-1:0]),
		.rd_data (lead_rd)
	);

	// Read address runs one step ahead so read data always matches idx_q.
	always_comb begin
		if (cmd.accept) begin
			idx_d = '0;
		end else if (cmd.ld_blank) begin
			idx_d = idx_q + LEAD_CW'(1);
		end else begin
			idx_d = idx_q;
		end
	end

	// Line state next values.
	always_comb begin
		mode_d       = mode_q;
		column_d     = column_q;
		lead_count_d = lead_count_q;
		saw_bad_d    = saw_bad_q;
		saw_ovf_d    = saw_ovf_q;
		if (cmd.ld_nl) begin
			mode_d       = M_LEAD;
			column_d     = '0;
			lead_count_d = '0;
			saw_bad_d    = 1'b0;
			saw_ovf_d    = 1'b0;
		end else begin
			if (cmd.accept) begin
				mode_d = dec_mode;
				if (dec_lead_wr) begin
					lead_count_d = lead_count_q + LEAD_CW'(1);
				end
				if (dec_lead_ovf) begin
					saw_ovf_d = 1'b1;
				end
				if (dec_bad) begin
					saw_bad_d = 1'b1;
				end
			end
			if (cmd.ld_tab) begin
				if (column_q >= TAB_SAT) begin
					column_d  = COL_MAX;
					saw_ovf_d = 1'b1;
				end else begin
					column_d = (column_q + COL_W'(TAB_WIDTH)) & TAB_MASK;
				end
			end
			if (cmd.ld_char && mode_q != M_RAW) begin
				if (column_q == COL_MAX) begin
					saw_ovf_d = 1'b1;
				end else begin
					column_d = column_q + COL_W'(1);
				end
			end
		end
	end

	assign load = cmd.ld_tab || cmd.ld_char || cmd.ld_blank || cmd.ld_semi || cmd.ld_nl;

	always_comb begin
		if (cmd.ld_char) begin
			load_char = char_q;
		end else if (cmd.ld_blank) begin
			load_char = lead_rd ? CH_TAB : CH_SP;
		end else if (cmd.ld_semi) begin
			load_char = CH_SEMI;
		end else if (cmd.ld_nl) begin
			load_char = CH_NL;
		end else begin
			load_char = CH_TAB;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_LEAD;
			column_q     <= '0;
			lead_count_q <= '0;
			idx_q        <= '0;
			saw_bad_q    <= 1'b0;
			saw_ovf_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			mode_q       <= mode_d;
			column_q     <= column_d;
			lead_count_q <= lead_count_d;
			idx_q        <= idx_d;
			saw_bad_q    <= saw_bad_d;
			saw_ovf_q    <= saw_ovf_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: hold the byte, load results.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			char_q <= in_char;
		end
		if (load) begin
			out_char_q  <= load_char;
			line_done_q <= cmd.ld_nl;
			bad_line_q  <= cmd.ld_nl && saw_bad_q;
			overflow_q  <= cmd.ld_nl && saw_ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign line_done = line_done_q;
	assign bad_line  = bad_line_q;
	assign overflow  = overflow_q;

endmodule

### src/asm_line_field_aligner.sv
// Top level of the assembler line field aligner.
//
// Input channel (in_valid / in_stall / in_char / line_end) takes one byte of a
// source line per transfer; a transfer with line_end high closes the line.
// Output channel (out_valid / out_stall / out_char / line_done / bad_line /
// overflow) gives the reformatted bytes; the newline carries line_done and
// the bad_line / overflow flags of the whole line.
// An item is taken while the input is free; its results then leave at one
// per cycle into the output register while the output is not stalled. The
// accept is registered in the sequencer state, from which the first result
// is loaded. A byte with results stalls the input until all are loaded; one
// with none (blanks, dropped text, zero bytes) does not stall it. Tab padding
// to the comment column and the replay of stored leading blanks give one
// result per tab or blank; replay reads one RAM entry per unstalled cycle.
// A stall on the output holds the output register and the sequencer; the
// input stays stalled until the current item's results are all loaded.
// Reset clears the field state, the column, the blank count, the flags and
// the output valid; the blank RAM has no reset and needs no clearing pass.
module asm_line_field_aligner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       line_done,
	output logic       bad_line,
	output logic       overflow
);
	import alf_pkg::*;

	alf_status_t sts;
	alf_cmd_t    cmd;

	// Sequencer: decide which result goes out each cycle.
	alf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: decode fields, track column, store blanks, hold the result.
	alf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_char   (in_char),
		.line_end  (line_end),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.line_done (line_done),
		.bad_line  (bad_line),
		.overflow  (overflow)
	);

	// A line-done result is always the newline.
	a_done_is_nl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> out_char == CH_NL)
		else $error("line_done result is not a newline");

	// Line flags appear only on the line-done result.
	a_flags_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (bad_line || overflow) |-> line_done)
		else $error("line flags outside the line-done result");

	// A new item is never taken in a cycle that loads a result.
	a_no_accept_on_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> !(cmd.ld_tab || cmd.ld_char || cmd.ld_blank ||
			cmd.ld_semi || cmd.ld_nl))
		else $error("accept overlaps a result load");

	// Loading a result over one that is stalled would lose it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> !(cmd.ld_tab || cmd.ld_char || cmd.ld_blank ||
			cmd.ld_semi || cmd.ld_nl))
		else $error("result loaded over a stalled result");

endmodule
